// File: design/assert_macros.svh
// Shared assertion macros for the pre-delay block.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property that must hold at every clock edge outside reset.
`define ASSERT_RST(label, clk, rstn, prop) \
    label: assert property (@(posedge clk) disable iff (!rstn) (prop)) \
        else $error("assertion failed");

// Condition that must never be seen outside reset.
`define ASSERT_NEVER(label, clk, rstn, cond) \
    label: assert property (@(posedge clk) disable iff (!rstn) !(cond)) \
        else $error("forbidden condition seen");

`endif

// File: design/sfp_pkg.sv
package sfp_pkg;

    localparam int DELAY_DEPTH = 16384;
    localparam int SAMPLE_BITS = 24;

    localparam int ADDR_BITS   = $clog2(DELAY_DEPTH);
    localparam int FRAC_BITS   = 16;
    localparam int NOW_BITS    = ADDR_BITS + FRAC_BITS;
    localparam int STEP_BITS   = NOW_BITS + 1;
    localparam int TARGET_BITS = 22;
    localparam int TARGET_FRAC = 8;
    localparam int RAMP_BITS   = 16;
    localparam int PROD_BITS   = SAMPLE_BITS + 1 + FRAC_BITS + 1;

    localparam int CFG_INDEX_BITS = 2;
    localparam int CFG_DATA_BITS  = TARGET_BITS;

    localparam logic [CFG_INDEX_BITS-1:0] REG_TARGET_DELAY  = 2'd0;
    localparam logic [CFG_INDEX_BITS-1:0] REG_RAMP_LENGTH   = 2'd1;
    localparam logic [CFG_INDEX_BITS-1:0] REG_STEREO_ENABLE = 2'd2;

    localparam logic [TARGET_BITS-1:0] TARGET_MAX = TARGET_BITS'((DELAY_DEPTH - 2) * 256);
    localparam logic [ADDR_BITS-1:0]   P_MAX      = ADDR_BITS'(DELAY_DEPTH - 2);
    localparam logic [RAMP_BITS-1:0]   RAMP_RESET = RAMP_BITS'(2400);

    localparam int QUEUE_DEPTH    = 4;
    localparam int QUEUE_PTR_BITS = $clog2(QUEUE_DEPTH);

    localparam int DIV_STEPS    = NOW_BITS;
    localparam int DIV_CNT_BITS = $clog2(DIV_STEPS);

    typedef logic signed [SAMPLE_BITS-1:0] sample_t;

    typedef struct packed {
        sample_t                left;
        sample_t                right;
        logic [ADDR_BITS-1:0]   p;
        logic [FRAC_BITS-1:0]   f;
        logic [ADDR_BITS-1:0]   wp;
        logic                   stereo;
    } queue_entry_t;

    typedef struct packed {
        logic                        start;
        logic                        clear;
        logic signed [STEP_BITS-1:0] dividend;
        logic [RAMP_BITS-1:0]        divisor;
    } div_req_t;

    typedef struct packed {
        logic                        busy;
        logic                        done;
        logic signed [STEP_BITS-1:0] quotient;
    } div_rsp_t;

endpackage

// File: design/sfp_div.sv
`include "assert_macros.svh"

module sfp_div (
    input  logic            aclk,
    input  logic            aresetn,
    input  sfp_pkg::div_req_t req,
    output sfp_pkg::div_rsp_t rsp
);
    import sfp_pkg::*;

    logic                    busy_reg;
    logic                    done_reg;
    logic                    neg_reg;
    logic [DIV_CNT_BITS-1:0] cnt_reg;
    logic [NOW_BITS-1:0]     num_reg;
    logic [RAMP_BITS-1:0]    den_reg;
    logic [RAMP_BITS-1:0]    rem_reg;

    logic signed [STEP_BITS-1:0] mag_full;
    logic [RAMP_BITS:0]          trial;
    logic                        q_bit;
    logic [RAMP_BITS:0]          trial_sub;

    always_comb begin
        mag_full  = req.dividend[STEP_BITS-1] ? -req.dividend : req.dividend;
        trial     = {rem_reg, num_reg[NOW_BITS-1]};
        q_bit     = (trial >= {1'b0, den_reg});
        trial_sub = trial - {1'b0, den_reg};
    end

    // control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (req.clear) begin
                busy_reg <= 1'b0;
            end else if (req.start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end else if (busy_reg) begin
                if (cnt_reg == DIV_CNT_BITS'(DIV_STEPS - 1)) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end else begin
                    cnt_reg <= cnt_reg + 1'b1;
                end
            end
        end
    end

    // restoring division, one quotient bit per cycle shifted in behind the dividend
    always_ff @(posedge aclk) begin
        if (req.start) begin
            num_reg <= mag_full[NOW_BITS-1:0];
            den_reg <= req.divisor;
            neg_reg <= req.dividend[STEP_BITS-1];
            rem_reg <= '0;
        end else if (busy_reg) begin
            rem_reg <= q_bit ? trial_sub[RAMP_BITS-1:0] : trial[RAMP_BITS-1:0];
            num_reg <= {num_reg[NOW_BITS-2:0], q_bit};
        end
    end

    always_comb begin
        rsp.busy     = busy_reg;
        rsp.done     = done_reg;
        rsp.quotient = neg_reg ? -signed'({1'b0, num_reg}) : signed'({1'b0, num_reg});
    end

    `ASSERT_RST(a_start_busy, aclk, aresetn, (req.start && !req.clear) |=> busy_reg)
    `ASSERT_NEVER(a_done_busy, aclk, aresetn, done_reg && busy_reg)

endmodule

// File: design/sfp_queue.sv
`include "assert_macros.svh"

module sfp_queue (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  push,
    input  sfp_pkg::queue_entry_t push_entry,
    output logic                  full,
    input  logic                  pop,
    output logic                  head_valid,
    output sfp_pkg::queue_entry_t head_entry
);
    import sfp_pkg::*;

    queue_entry_t              slot_reg [QUEUE_DEPTH];
    logic [QUEUE_PTR_BITS-1:0] wr_ptr_reg;
    logic [QUEUE_PTR_BITS-1:0] rd_ptr_reg;
    logic [QUEUE_PTR_BITS:0]   count_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (push) begin
                wr_ptr_reg <= (wr_ptr_reg == QUEUE_PTR_BITS'(QUEUE_DEPTH - 1)) ?
                              '0 : wr_ptr_reg + 1'b1;
            end
            if (pop) begin
                rd_ptr_reg <= (rd_ptr_reg == QUEUE_PTR_BITS'(QUEUE_DEPTH - 1)) ?
                              '0 : rd_ptr_reg + 1'b1;
            end
            if (push && !pop) begin
                count_reg <= count_reg + 1'b1;
            end else if (pop && !push) begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            slot_reg[wr_ptr_reg] <= push_entry;
        end
    end

    assign full       = (count_reg == (QUEUE_PTR_BITS + 1)'(QUEUE_DEPTH));
    assign head_valid = (count_reg != '0);
    assign head_entry = slot_reg[rd_ptr_reg];

    `ASSERT_NEVER(a_push_full, aclk, aresetn, push && full)
    `ASSERT_NEVER(a_pop_empty, aclk, aresetn, pop && !head_valid)

endmodule

// File: design/sfp_front.sv
module sfp_front (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                cfg_we,
    input  logic [sfp_pkg::CFG_INDEX_BITS-1:0]  cfg_index,
    input  logic [sfp_pkg::CFG_DATA_BITS-1:0]   cfg_data,
    input  logic                                s_valid,
    output logic                                s_ready,
    input  logic signed [sfp_pkg::SAMPLE_BITS-1:0] s_left_in,
    input  logic signed [sfp_pkg::SAMPLE_BITS-1:0] s_right_in,
    input  logic                                init_done,
    input  logic                                q_full,
    output logic                                q_push,
    output sfp_pkg::queue_entry_t               q_entry,
    output sfp_pkg::div_req_t                   div_req,
    input  sfp_pkg::div_rsp_t                   div_rsp
);
    import sfp_pkg::*;

    logic [TARGET_BITS-1:0]      target_reg;
    logic [RAMP_BITS-1:0]        ramp_reg;
    logic                        stereo_reg;
    logic [NOW_BITS-1:0]         delay_now_reg;
    logic signed [STEP_BITS-1:0] delay_step_reg;
    logic [RAMP_BITS-1:0]        steps_left_reg;
    logic [ADDR_BITS-1:0]        write_pos_reg;

    logic [RAMP_BITS-1:0]        steps_left_next;
    logic [NOW_BITS-1:0]         delay_now_next;
    logic [ADDR_BITS-1:0]        write_pos_next;
    logic signed [STEP_BITS-1:0] glide_sum;
    logic [NOW_BITS-1:0]         target_now;
    logic [TARGET_BITS-1:0]      target_sat;
    logic [NOW_BITS-1:0]         target_sat_now;
    logic [ADDR_BITS-1:0]        p_raw;
    logic                        target_change;

    assign s_ready = init_done && !q_full && !div_rsp.busy && !div_rsp.done;
    assign q_push  = s_valid && s_ready;

    // glide advance for the accepted transaction
    always_comb begin
        target_now      = {target_reg, {(FRAC_BITS - TARGET_FRAC){1'b0}}};
        glide_sum       = signed'({1'b0, delay_now_reg}) + delay_step_reg;
        steps_left_next = steps_left_reg;
        delay_now_next  = delay_now_reg;
        if (steps_left_reg != '0) begin
            steps_left_next = steps_left_reg - 1'b1;
            delay_now_next  = (steps_left_next != '0) ? glide_sum[NOW_BITS-1:0] : target_now;
        end
        p_raw          = delay_now_next[NOW_BITS-1:FRAC_BITS];
        write_pos_next = (write_pos_reg == ADDR_BITS'(DELAY_DEPTH - 1)) ?
                         '0 : write_pos_reg + 1'b1;
    end

    always_comb begin
        q_entry.left   = s_left_in;
        q_entry.right  = s_right_in;
        q_entry.p      = (p_raw > P_MAX) ? P_MAX : p_raw;
        q_entry.f      = delay_now_next[FRAC_BITS-1:0];
        q_entry.wp     = write_pos_reg;
        q_entry.stereo = stereo_reg;
    end

    // target write: saturate, then either jump or launch the step division
    always_comb begin
        target_sat       = (cfg_data[TARGET_BITS-1:0] > TARGET_MAX) ?
                           TARGET_MAX : cfg_data[TARGET_BITS-1:0];
        target_sat_now   = {target_sat, {(FRAC_BITS - TARGET_FRAC){1'b0}}};
        target_change    = cfg_we && (cfg_index == REG_TARGET_DELAY) &&
                           (target_sat != target_reg);
        div_req.start    = target_change && (ramp_reg != '0);
        div_req.clear    = target_change && (ramp_reg == '0);
        div_req.dividend = signed'({1'b0, target_sat_now}) - signed'({1'b0, delay_now_reg});
        div_req.divisor  = ramp_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            target_reg     <= '0;
            ramp_reg       <= RAMP_RESET;
            stereo_reg     <= 1'b1;
            delay_now_reg  <= '0;
            delay_step_reg <= '0;
            steps_left_reg <= '0;
            write_pos_reg  <= '0;
        end else begin
            if (q_push) begin
                steps_left_reg <= steps_left_next;
                delay_now_reg  <= delay_now_next;
                write_pos_reg  <= write_pos_next;
            end
            if (div_rsp.done) begin
                delay_step_reg <= div_rsp.quotient;
            end
            if (cfg_we) begin
                unique case (cfg_index)
                    REG_TARGET_DELAY: begin
                        if (target_change) begin
                            target_reg <= target_sat;
                            if (ramp_reg == '0) begin
                                delay_now_reg  <= target_sat_now;
                                steps_left_reg <= '0;
                                delay_step_reg <= '0;
                            end else begin
                                steps_left_reg <= ramp_reg;
                            end
                        end
                    end
                    REG_RAMP_LENGTH: begin
                        ramp_reg <= cfg_data[RAMP_BITS-1:0];
                    end
                    REG_STEREO_ENABLE: begin
                        stereo_reg <= cfg_data[0];
                    end
                    default: begin
                        // drop writes beyond the register list
                    end
                endcase
            end
        end
    end

endmodule

// File: design/sfp_back.sv
`include "assert_macros.svh"

module sfp_back (
    input  logic                                   aclk,
    input  logic                                   aresetn,
    input  logic                                   q_valid,
    input  sfp_pkg::queue_entry_t                  q_entry,
    output logic                                   q_pop,
    output logic                                   init_done,
    output logic                                   m_valid,
    input  logic                                   m_ready,
    output logic signed [sfp_pkg::SAMPLE_BITS-1:0] m_left_out,
    output logic signed [sfp_pkg::SAMPLE_BITS-1:0] m_right_out
);
    import sfp_pkg::*;

    sample_t left_mem  [DELAY_DEPTH];
    sample_t right_mem [DELAY_DEPTH];

    logic [ADDR_BITS-1:0] clr_addr_reg;
    logic                 clr_done_reg;

    logic s1_valid_reg;
    logic s2_valid_reg;
    logic out_valid_reg;

    sample_t              s1_la_reg, s1_lb_reg, s1_ra_reg, s1_rb_reg;
    logic [FRAC_BITS-1:0] s1_f_reg;
    logic                 s1_stereo_reg;

    sample_t                     s2_la_reg, s2_ra_reg;
    logic signed [PROD_BITS-1:0] s2_lprod_reg, s2_rprod_reg;
    logic                        s2_stereo_reg;

    sample_t out_left_reg, out_right_reg;

    logic                 advance;
    logic                 issue;
    logic [ADDR_BITS:0]   back_diff;
    logic [ADDR_BITS-1:0] rd_a;
    logic [ADDR_BITS-1:0] rd_b;
    logic [ADDR_BITS-1:0] waddr;
    logic                 left_we, right_we;
    sample_t              left_wdata, right_wdata;

    logic signed [SAMPLE_BITS:0]   ldiff, rdiff;
    logic signed [FRAC_BITS:0]     f_ext;
    logic signed [PROD_BITS-1:0]   lsum, rsum;

    assign advance   = !out_valid_reg || m_ready;
    assign issue     = q_valid && advance && clr_done_reg;
    assign q_pop     = issue;
    assign init_done = clr_done_reg;

    // entry p back and entry p+1 back from the write position
    always_comb begin
        back_diff = {1'b0, q_entry.wp} - {1'b0, q_entry.p};
        rd_a      = back_diff[ADDR_BITS] ?
                    ADDR_BITS'(back_diff + (ADDR_BITS + 1)'(DELAY_DEPTH)) :
                    back_diff[ADDR_BITS-1:0];
        rd_b      = (rd_a == '0) ? ADDR_BITS'(DELAY_DEPTH - 1) : rd_a - 1'b1;
    end

    // the clearing pass owns the write port until it is done
    always_comb begin
        waddr       = clr_done_reg ? q_entry.wp : clr_addr_reg;
        left_we     = !clr_done_reg || issue;
        right_we    = !clr_done_reg || (issue && q_entry.stereo);
        left_wdata  = clr_done_reg ? q_entry.left  : '0;
        right_wdata = clr_done_reg ? q_entry.right : '0;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            clr_addr_reg <= '0;
            clr_done_reg <= 1'b0;
        end else if (!clr_done_reg) begin
            if (clr_addr_reg == ADDR_BITS'(DELAY_DEPTH - 1)) begin
                clr_done_reg <= 1'b1;
            end else begin
                clr_addr_reg <= clr_addr_reg + 1'b1;
            end
        end
    end

    // reads see the old contents when the write hits the same entry
    always_ff @(posedge aclk) begin
        if (left_we) begin
            left_mem[waddr] <= left_wdata;
        end
        if (right_we) begin
            right_mem[waddr] <= right_wdata;
        end
        if (issue) begin
            s1_la_reg     <= left_mem[rd_a];
            s1_lb_reg     <= left_mem[rd_b];
            s1_ra_reg     <= right_mem[rd_a];
            s1_rb_reg     <= right_mem[rd_b];
            s1_f_reg      <= q_entry.f;
            s1_stereo_reg <= q_entry.stereo;
        end
    end

    always_comb begin
        ldiff = signed'({s1_lb_reg[SAMPLE_BITS-1], s1_lb_reg}) -
                signed'({s1_la_reg[SAMPLE_BITS-1], s1_la_reg});
        rdiff = signed'({s1_rb_reg[SAMPLE_BITS-1], s1_rb_reg}) -
                signed'({s1_ra_reg[SAMPLE_BITS-1], s1_ra_reg});
        f_ext = signed'({1'b0, s1_f_reg});
        lsum  = ((s2_lprod_reg + PROD_BITS'(32768)) >>> FRAC_BITS) + PROD_BITS'(s2_la_reg);
        rsum  = ((s2_rprod_reg + PROD_BITS'(32768)) >>> FRAC_BITS) + PROD_BITS'(s2_ra_reg);
    end

    // hold every stage while the output waits
    always_ff @(posedge aclk) begin
        if (advance) begin
            s2_la_reg     <= s1_la_reg;
            s2_ra_reg     <= s1_ra_reg;
            s2_lprod_reg  <= PROD_BITS'(ldiff) * PROD_BITS'(f_ext);
            s2_rprod_reg  <= PROD_BITS'(rdiff) * PROD_BITS'(f_ext);
            s2_stereo_reg <= s1_stereo_reg;
            out_left_reg  <= lsum[SAMPLE_BITS-1:0];
            out_right_reg <= s2_stereo_reg ? rsum[SAMPLE_BITS-1:0] : '0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg  <= 1'b0;
            s2_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else if (advance) begin
            s1_valid_reg  <= issue;
            s2_valid_reg  <= s1_valid_reg;
            out_valid_reg <= s2_valid_reg;
        end
    end

    assign m_valid     = out_valid_reg;
    assign m_left_out  = out_left_reg;
    assign m_right_out = out_right_reg;

    `ASSERT_RST(a_issue_after_clear, aclk, aresetn, issue |-> clr_done_reg)
    `ASSERT_RST(a_stall_holds, aclk, aresetn, (s2_valid_reg && !advance) |=> s2_valid_reg)

endmodule

// File: design/stereo_fractional_predelay.sv
// Stereo fractional pre-delay with linear interpolation. Each input transaction carries one
// left/right sample pair and yields one output transaction, delayed by target_delay (samples,
// 8 fraction bits, capped at 16382.0) with linear interpolation between adjacent stored
// samples. A target change glides over ramp_length samples (0 jumps). With stereo_enable low
// only the left channel is stored and produced and right_out reads zero. Throughput is one
// transaction per cycle while the output is taken and no division runs: the dual-port sample
// stores read both neighbors and write the new sample in the same cycle, and a four-entry
// queue between the delay tracker and the interpolation pipeline lets input and output stall
// independently. An accepted transaction passes the queue, then the read, product and output
// registers. After a write that changes the target with a nonzero ramp, s_ready stays low
// while the per-sample step is divided out, one bit per cycle. After reset, s_ready stays low
// while the sample stores are cleared; configuration writes are taken during that time.
module stereo_fractional_predelay (
    input  logic                                   aclk,
    input  logic                                   aresetn,
    input  logic                                   cfg_we,
    input  logic [sfp_pkg::CFG_INDEX_BITS-1:0]     cfg_index,
    input  logic [sfp_pkg::CFG_DATA_BITS-1:0]      cfg_data,
    input  logic                                   s_valid,
    output logic                                   s_ready,
    input  logic signed [sfp_pkg::SAMPLE_BITS-1:0] s_left_in,
    input  logic signed [sfp_pkg::SAMPLE_BITS-1:0] s_right_in,
    output logic                                   m_valid,
    input  logic                                   m_ready,
    output logic signed [sfp_pkg::SAMPLE_BITS-1:0] m_left_out,
    output logic signed [sfp_pkg::SAMPLE_BITS-1:0] m_right_out
);
    import sfp_pkg::*;

    logic         init_done;
    logic         q_full;
    logic         q_push;
    logic         q_pop;
    logic         q_valid;
    queue_entry_t push_entry;
    queue_entry_t head_entry;
    div_req_t     div_req;
    div_rsp_t     div_rsp;

    sfp_div u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (div_req),
        .rsp     (div_rsp)
    );

    sfp_front u_front (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cfg_we     (cfg_we),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .s_valid    (s_valid),
        .s_ready    (s_ready),
        .s_left_in  (s_left_in),
        .s_right_in (s_right_in),
        .init_done  (init_done),
        .q_full     (q_full),
        .q_push     (q_push),
        .q_entry    (push_entry),
        .div_req    (div_req),
        .div_rsp    (div_rsp)
    );

    sfp_queue u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push       (q_push),
        .push_entry (push_entry),
        .full       (q_full),
        .pop        (q_pop),
        .head_valid (q_valid),
        .head_entry (head_entry)
    );

    sfp_back u_back (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .q_valid     (q_valid),
        .q_entry     (head_entry),
        .q_pop       (q_pop),
        .init_done   (init_done),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_left_out  (m_left_out),
        .m_right_out (m_right_out)
    );

endmodule

// File: verif/tb_stereo_fractional_predelay.sv
`timescale 1ns / 100ps

module tb_stereo_fractional_predelay;
    import sfp_pkg::*;

    localparam logic [CFG_INDEX_BITS-1:0] REG_NONE = 2'd3;

    localparam sample_t S_MAX  = 24'sh7FFFFF;
    localparam sample_t S_MIN  = 24'sh800000;
    localparam sample_t S_ZERO = 24'sh000000;

    localparam int SETTLE_CYCLES   = 8;
    localparam int TAIL_CYCLES     = 16;
    localparam int RANDOM_ITEMS    = 1400;
    localparam int BACKLOG_FIRST   = 150;
    localparam int BACKLOG_SPACING = 700;
    localparam int BACKLOG_CYCLES  = 400;
    localparam int TIMEOUT_NS      = 2_000_000;

    typedef enum logic [1:0] {ROW_WRITE, ROW_PAIR, ROW_PAIR_CHECKED} row_kind_e;

    typedef struct packed {
        row_kind_e                 kind;
        logic [CFG_INDEX_BITS-1:0] idx;
        logic [CFG_DATA_BITS-1:0]  data;
        sample_t                   left;
        sample_t                   right;
        sample_t                   left_exp;
        sample_t                   right_exp;
    } plan_row_t;

    typedef struct packed {
        sample_t left;
        sample_t right;
    } stereo_pair_t;

    localparam int PLAN_ROWS = 33;
    localparam plan_row_t DIRECTED_PLAN [PLAN_ROWS] = '{
        '{ROW_WRITE, REG_RAMP_LENGTH, 22'd0, S_ZERO, S_ZERO, S_ZERO, S_ZERO},
        // delay zero reads the slot about to be overwritten: still cleared
        '{ROW_PAIR_CHECKED, REG_NONE, 22'd0, S_MAX, S_MIN, S_ZERO, S_ZERO},
        '{ROW_WRITE, REG_TARGET_DELAY, 22'd256, S_ZERO, S_ZERO, S_ZERO, S_ZERO},
        '{ROW_PAIR_CHECKED, REG_NONE, 22'd0, S_MIN, S_MAX, S_MAX, S_MIN},
        '{ROW_PAIR_CHECKED, REG_NONE, 22'd0, S_ZERO, -24'sd1, S_MIN, S_MAX},
        '{ROW_WRITE, REG_TARGET_DELAY, 22'd384, S_ZERO, S_ZERO, S_ZERO, S_ZERO},
        '{ROW_PAIR, REG_NONE, 22'd0, 24'sd1, -24'sd1, S_ZERO, S_ZERO},
        '{ROW_PAIR, REG_NONE, 22'd0, S_MAX, S_MAX, S_ZERO, S_ZERO},
        // saturates to the deepest tap, which has never been written
        '{ROW_WRITE, REG_TARGET_DELAY, 22'h3FFFFF, S_ZERO, S_ZERO, S_ZERO, S_ZERO},
        '{ROW_PAIR_CHECKED, REG_NONE, 22'd0, S_MIN, S_MIN, S_ZERO, S_ZERO},
        '{ROW_WRITE, REG_TARGET_DELAY, TARGET_MAX, S_ZERO, S_ZERO, S_ZERO, S_ZERO},
        '{ROW_PAIR_CHECKED, REG_NONE, 22'd0, S_MAX, S_MIN, S_ZERO, S_ZERO},
        '{ROW_WRITE, REG_RAMP_LENGTH, 22'd65535, S_ZERO, S_ZERO, S_ZERO, S_ZERO},
        '{ROW_WRITE, REG_TARGET_DELAY, 22'd0, S_ZERO, S_ZERO, S_ZERO, S_ZERO},
        '{ROW_PAIR, REG_NONE, 22'd0, 24'sh123456, -24'sh0ABCDE, S_ZERO, S_ZERO},
        '{ROW_PAIR, REG_NONE, 22'd0, 24'sh555555, 24'shAAAAAA, S_ZERO, S_ZERO},
        // new ramp must not disturb the glide already running
        '{ROW_WRITE, REG_RAMP_LENGTH, 22'd1, S_ZERO, S_ZERO, S_ZERO, S_ZERO},
        '{ROW_PAIR, REG_NONE, 22'd0, -24'sh3C3C3C, 24'sh0F0F0F, S_ZERO, S_ZERO},
        '{ROW_WRITE, REG_TARGET_DELAY, 22'd512, S_ZERO, S_ZERO, S_ZERO, S_ZERO},
        '{ROW_PAIR, REG_NONE, 22'd0, 24'sh400000, -24'sh400000, S_ZERO, S_ZERO},
        '{ROW_WRITE, REG_STEREO_ENABLE, 22'd0, S_ZERO, S_ZERO, S_ZERO, S_ZERO},
        '{ROW_PAIR, REG_NONE, 22'd0, 24'sd100, 24'sd200, S_ZERO, S_ZERO},
        '{ROW_PAIR, REG_NONE, 22'd0, -24'sd5, 24'sd7, S_ZERO, S_ZERO},
        '{ROW_WRITE, REG_NONE, 22'h3FFFFF, S_ZERO, S_ZERO, S_ZERO, S_ZERO},
        '{ROW_PAIR, REG_NONE, 22'd0, 24'sh7F0000, S_MIN, S_ZERO, S_ZERO},
        // right side reads back whatever it held before mono
        '{ROW_WRITE, REG_STEREO_ENABLE, 22'd1, S_ZERO, S_ZERO, S_ZERO, S_ZERO},
        '{ROW_PAIR, REG_NONE, 22'd0, -24'sd1000, 24'sd1000, S_ZERO, S_ZERO},
        '{ROW_PAIR, REG_NONE, 22'd0, S_MIN, S_MAX, S_ZERO, S_ZERO},
        '{ROW_WRITE, REG_RAMP_LENGTH, 22'd3, S_ZERO, S_ZERO, S_ZERO, S_ZERO},
        '{ROW_WRITE, REG_TARGET_DELAY, 22'd300, S_ZERO, S_ZERO, S_ZERO, S_ZERO},
        '{ROW_PAIR, REG_NONE, 22'd0, 24'sh010203, -24'sh030201, S_ZERO, S_ZERO},
        '{ROW_PAIR, REG_NONE, 22'd0, S_MAX, S_ZERO, S_ZERO, S_ZERO},
        '{ROW_PAIR, REG_NONE, 22'd0, -24'sh2AAAAA, 24'sh2AAAAA, S_ZERO, S_ZERO}
    };

    logic                      aclk;
    logic                      aresetn;
    logic                      cfg_we;
    logic [CFG_INDEX_BITS-1:0] cfg_index;
    logic [CFG_DATA_BITS-1:0]  cfg_data;
    logic                      s_valid;
    logic                      s_ready;
    sample_t                   s_left_in;
    sample_t                   s_right_in;
    logic                      m_valid;
    logic                      m_ready;
    sample_t                   m_left_out;
    sample_t                   m_right_out;

    // Mirror of the delay line
    sample_t                mirror_left  [DELAY_DEPTH];
    sample_t                mirror_right [DELAY_DEPTH];
    logic [ADDR_BITS-1:0]   wr_ptr      = '0;
    longint                 delay_fx    = 0;
    longint                 glide_inc   = 0;
    logic [RAMP_BITS-1:0]   glides_left = '0;
    logic [TARGET_BITS-1:0] target_q8   = '0;
    logic [RAMP_BITS-1:0]   glide_len   = RAMP_RESET;
    bit                     stereo_on   = 1'b1;

    stereo_pair_t pending_pairs [$];
    int           mismatch_count = 0;
    int           outputs_taken  = 0;
    bit           fixed_check    = 1'b0;
    sample_t      fixed_left     = '0;
    sample_t      fixed_right    = '0;

    stereo_fractional_predelay u_top (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_we      (cfg_we),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_left_in   (s_left_in),
        .s_right_in  (s_right_in),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_left_out  (m_left_out),
        .m_right_out (m_right_out)
    );

    initial begin
        aclk = 1'b0;
        forever #1 aclk = ~aclk;
    end

    initial begin
        #(TIMEOUT_NS);
        $display("DONE: errors detected");
        $finish;
    end

    function automatic void apply_setting(input logic [CFG_INDEX_BITS-1:0] idx,
                                          input logic [CFG_DATA_BITS-1:0] data);
        logic [TARGET_BITS-1:0] t;
        case (idx)
            REG_TARGET_DELAY: begin
                t = (data > TARGET_MAX) ? TARGET_MAX : data;
                if (t != target_q8) begin
                    target_q8 = t;
                    if (glide_len == 0) begin
                        delay_fx    = longint'(t) << 8;
                        glides_left = '0;
                        glide_inc   = 0;
                    end else begin
                        glides_left = glide_len;
                        glide_inc   = ((longint'(t) << 8) - delay_fx) / longint'(glide_len);
                    end
                end
            end
            REG_RAMP_LENGTH:   glide_len = data[RAMP_BITS-1:0];
            REG_STEREO_ENABLE: stereo_on = data[0];
            default: ;
        endcase
    endfunction

    function automatic sample_t blend(input sample_t a, input sample_t b, input longint frac);
        longint num;
        num = (longint'(b) - longint'(a)) * frac + 32768;
        return sample_t'(longint'(a) + (num >>> 16));
    endfunction

    // Advance the glide, read two neighbors per channel, then store the new pair
    function automatic void delay_line_step(input sample_t l_in, input sample_t r_in,
                                            output sample_t l_out, output sample_t r_out);
        longint               tap;
        longint               frac;
        logic [ADDR_BITS-1:0] near_idx;
        logic [ADDR_BITS-1:0] far_idx;
        if (glides_left != 0) begin
            glides_left--;
            if (glides_left != 0)
                delay_fx = delay_fx + glide_inc;
            else
                delay_fx = longint'(target_q8) << 8;
        end
        tap = delay_fx >>> FRAC_BITS;
        if (tap > DELAY_DEPTH - 2)
            tap = DELAY_DEPTH - 2;
        frac     = delay_fx & 64'hFFFF;
        near_idx = wr_ptr - ADDR_BITS'(tap);
        far_idx  = near_idx - 1'b1;
        l_out = blend(mirror_left[near_idx], mirror_left[far_idx], frac);
        r_out = stereo_on ? blend(mirror_right[near_idx], mirror_right[far_idx], frac) : S_ZERO;
        mirror_left[wr_ptr] = l_in;
        if (stereo_on)
            mirror_right[wr_ptr] = r_in;
        wr_ptr = wr_ptr + 1'b1;
    endfunction

    task automatic compare_sample(input string field, input sample_t want, input sample_t got);
        if (got !== want) begin
            $error("%s mismatch: expected %0d, got %0d", field, want, got);
            mismatch_count++;
        end
    endtask

    always @(posedge aclk) begin : monitor
        stereo_pair_t want;
        if (aresetn) begin
            if (cfg_we)
                apply_setting(cfg_index, cfg_data);
            if (s_valid && s_ready) begin
                delay_line_step(s_left_in, s_right_in, want.left, want.right);
                if (fixed_check) begin
                    want.left  = fixed_left;
                    want.right = fixed_right;
                end
                pending_pairs.push_back(want);
            end
            if (m_valid && m_ready) begin
                if (pending_pairs.size() == 0) begin
                    $error("output transaction with nothing expected");
                    mismatch_count++;
                end else begin
                    want = pending_pairs.pop_front();
                    compare_sample("left_out", want.left, m_left_out);
                    compare_sample("right_out", want.right, m_right_out);
                end
                outputs_taken++;
            end
        end
    end

    function automatic int pick_gap();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        if (r < 85)
            return $urandom_range(1, 3);
        if (r < 96)
            return $urandom_range(4, 10);
        return $urandom_range(20, 60);
    endfunction

    initial begin : sink
        int run_left;
        int stall_left;
        int backlog_idx;
        run_left    = 0;
        stall_left  = 0;
        backlog_idx = 0;
        m_ready     = 1'b0;
        forever begin
            @(negedge aclk);
            if (stall_left != 0) begin
                m_ready <= 1'b0;
                stall_left--;
            end else if (backlog_idx < 2 && s_valid &&
                         outputs_taken >= BACKLOG_FIRST + BACKLOG_SPACING * backlog_idx) begin
                // hold off long enough for the block to back up into its input
                m_ready <= 1'b0;
                stall_left = BACKLOG_CYCLES - 1;
                backlog_idx++;
            end else begin
                m_ready <= 1'b1;
                if (run_left != 0) begin
                    run_left--;
                end else begin
                    run_left   = ($urandom_range(0, 9) == 0) ? $urandom_range(100, 300)
                                                             : $urandom_range(0, 6);
                    stall_left = pick_gap();
                end
            end
        end
    end

    function automatic sample_t pick_sample();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 70)
            return sample_t'($urandom);
        if (r < 80) begin
            case ($urandom_range(0, 3))
                0:       return S_MAX;
                1:       return S_MIN;
                2:       return S_ZERO;
                default: return -24'sd1;
            endcase
        end
        return sample_t'(int'($urandom_range(0, 512)) - 256);
    endfunction

    function automatic logic [CFG_DATA_BITS-1:0] pick_target();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 35)
            return CFG_DATA_BITS'($urandom_range(0, 16 * 256));
        if (r < 60)
            return CFG_DATA_BITS'($urandom_range(0, 256 * 256));
        if (r < 75)
            return CFG_DATA_BITS'($urandom_range(0, TARGET_MAX));
        if (r < 85)
            return CFG_DATA_BITS'($urandom_range(TARGET_MAX + 1, 22'h3FFFFF));
        if (r < 92)
            return target_q8;
        return ($urandom_range(0, 1) == 0) ? '0 : TARGET_MAX;
    endfunction

    function automatic logic [CFG_DATA_BITS-1:0] pick_ramp();
        int unsigned            r;
        logic [CFG_DATA_BITS-1:0] word;
        r = $urandom_range(0, 99);
        if (r < 25)
            word = '0;
        else if (r < 75)
            word = CFG_DATA_BITS'($urandom_range(1, 64));
        else if (r < 90)
            word = CFG_DATA_BITS'($urandom_range(65, 2000));
        else
            word = ($urandom_range(0, 1) == 0) ? 22'd65535
                                               : CFG_DATA_BITS'($urandom_range(2001, 65535));
        // junk above the ramp field must be dropped
        if ($urandom_range(0, 3) == 0)
            word[CFG_DATA_BITS-1:RAMP_BITS] = (CFG_DATA_BITS - RAMP_BITS)'($urandom);
        return word;
    endfunction

    task automatic wait_drained();
        while (pending_pairs.size() != 0)
            @(negedge aclk);
        repeat (SETTLE_CYCLES) @(negedge aclk);
    endtask

    task automatic cfg_write(input logic [CFG_INDEX_BITS-1:0] idx,
                             input logic [CFG_DATA_BITS-1:0] data);
        @(negedge aclk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(negedge aclk);
        cfg_we    <= 1'b0;
    endtask

    task automatic send_pair(input sample_t l, input sample_t r);
        s_valid    <= 1'b1;
        s_left_in  <= l;
        s_right_in <= r;
        @(posedge aclk);
        while (!s_ready)
            @(posedge aclk);
        @(negedge aclk);
    endtask

    // Keep valid high into the next transaction unless a gap or a pause follows
    task automatic finish_item(input bit steady, input bit more);
        int gap;
        gap = steady ? 0 : pick_gap();
        if (gap != 0 || !more) begin
            s_valid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
    endtask

    initial begin : stimulus
        int                       random_sent;
        int                       burst;
        bit                       steady;
        bit                       more;
        logic [CFG_DATA_BITS-1:0] word;
        aresetn    = 1'b0;
        cfg_we     = 1'b0;
        cfg_index  = '0;
        cfg_data   = '0;
        s_valid    = 1'b0;
        s_left_in  = '0;
        s_right_in = '0;
        foreach (mirror_left[i]) begin
            mirror_left[i]  = '0;
            mirror_right[i] = '0;
        end
        repeat (4) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        for (int i = 0; i < PLAN_ROWS; i++) begin
            if (DIRECTED_PLAN[i].kind == ROW_WRITE) begin
                wait_drained();
                cfg_write(DIRECTED_PLAN[i].idx, DIRECTED_PLAN[i].data);
            end else begin
                fixed_check = (DIRECTED_PLAN[i].kind == ROW_PAIR_CHECKED);
                fixed_left  = DIRECTED_PLAN[i].left_exp;
                fixed_right = DIRECTED_PLAN[i].right_exp;
                send_pair(DIRECTED_PLAN[i].left, DIRECTED_PLAN[i].right);
                more = (i + 1 < PLAN_ROWS) && (DIRECTED_PLAN[i + 1].kind != ROW_WRITE);
                finish_item(1'b0, more);
            end
        end
        fixed_check = 1'b0;

        random_sent = 0;
        while (random_sent < RANDOM_ITEMS) begin
            wait_drained();
            if ($urandom_range(0, 1) == 0)
                cfg_write(REG_RAMP_LENGTH, pick_ramp());
            cfg_write(REG_TARGET_DELAY, pick_target());
            if ($urandom_range(0, 2) == 0)
                cfg_write(REG_RAMP_LENGTH, pick_ramp());
            if ($urandom_range(0, 1) == 0) begin
                word = '0;
                if ($urandom_range(0, 3) == 0)
                    word = CFG_DATA_BITS'($urandom);
                word[0] = 1'($urandom_range(0, 1));
                cfg_write(REG_STEREO_ENABLE, word);
            end
            if ($urandom_range(0, 9) == 0)
                cfg_write(REG_NONE, CFG_DATA_BITS'($urandom));
            steady = ($urandom_range(0, 3) == 0);
            burst  = $urandom_range(90, 150);
            for (int k = 0; k < burst; k++) begin
                send_pair(pick_sample(), pick_sample());
                finish_item(steady, k + 1 < burst);
                random_sent++;
            end
        end

        while (pending_pairs.size() != 0)
            @(negedge aclk);
        repeat (TAIL_CYCLES) @(negedge aclk);
        if (mismatch_count == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule

// File: files.f
+incdir+design
design/sfp_pkg.sv
design/sfp_div.sv
design/sfp_queue.sv
design/sfp_front.sv
design/sfp_back.sv
design/stereo_fractional_predelay.sv
verif/tb_stereo_fractional_predelay.sv
